[src/mvpc_pkg.sv]
// ----------------------------------------------------------------------------
// mvpc_pkg
// Types and constants for the mixing valve pulse controller.
// ----------------------------------------------------------------------------
package mvpc_pkg;

  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned MAXT_W    = 15;
  localparam int unsigned BAND_W    = 10;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned EXT_W     = 18;

  typedef enum logic [1:0] {
    VALVE_STOP  = 2'd0,
    VALVE_OPEN  = 2'd1,
    VALVE_CLOSE = 2'd2
  } valve_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_MAX_TEMP    = 3'd1,
    REG_DEADBAND    = 3'd2,
    REG_LARGE_ERROR = 3'd3,
    REG_REST_TICKS  = 3'd4,
    REG_OPEN_PULSE  = 3'd5,
    REG_CLOSE_PULSE = 3'd6
  } cfg_reg_t;

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST    = 16'sd0;
  localparam logic [MAXT_W-1:0]        MAX_TEMP_RST    = 15'd440;
  localparam logic [BAND_W-1:0]        DEADBAND_RST    = 10'd10;
  localparam logic [BAND_W-1:0]        LARGE_ERROR_RST = 10'd50;
  localparam logic [TICK_W-1:0]        REST_TICKS_RST  = 8'd30;
  localparam logic [TICK_W-1:0]        OPEN_PULSE_RST  = 8'd5;
  localparam logic [TICK_W-1:0]        CLOSE_PULSE_RST = 8'd10;

  // Wait count for a request of n ticks; zero acts as one.
  function automatic logic [TICK_W-1:0] tick_wait(input logic [TICK_W-1:0] n);
    tick_wait = (n == '0) ? '0 : n - 1'b1;
  endfunction

endpackage

[src/mixing_valve_pulse_controller_top.sv]
// ----------------------------------------------------------------------------
// mixing_valve_pulse_controller_top
// Pump and three-way mixing valve pulse controller, one temperature sample
// per tick transaction.
// ----------------------------------------------------------------------------
// One tick transaction is accepted per clock cycle while in_stall is low. Each
// transaction goes through an input register and is decided by compare logic
// into the result register; a result is valid once it is in the result
// register and is taken at an edge where out_stall is low. Pump and valve state
// update as each result is registered. While a result is held by out_stall
// the input register takes one more transaction, then in_stall stays high
// until the result is taken.
// Configuration writes are taken any time but must only be issued while idle.
// ----------------------------------------------------------------------------
module mixing_valve_pulse_controller_top
  import mvpc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_addr,
  input  logic [CFG_DAT_W-1:0]        cfg_wdata,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [TEMP_W-1:0]    in_temp_out,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pump_on,
  output logic [1:0]                  out_valve_cmd,
  output logic                        out_evaluated
);

  logic signed [TEMP_W-1:0] setpoint_r;
  logic [MAXT_W-1:0]        max_temp_r;
  logic [BAND_W-1:0]        deadband_r;
  logic [BAND_W-1:0]        large_error_r;
  logic [TICK_W-1:0]        rest_ticks_r;
  logic [TICK_W-1:0]        open_pulse_r;
  logic [TICK_W-1:0]        close_pulse_r;

  logic                     s1_valid_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic                     s1_adv;

  logic [TICK_W-1:0]        wait_left_r, wait_left_nxt;
  logic                     pump_r, pump_nxt;
  valve_t                   valve_r, valve_nxt;
  logic                     eval_nxt;

  logic                     out_valid_r;
  logic                     out_pump_r;
  valve_t                   out_valve_r;
  logic                     out_eval_r;

  logic signed [EXT_W-1:0]  sp_x, temp_x, maxt_x, db_x, big_x;
  logic signed [EXT_W-1:0]  cold_err, hot_err;
  logic                     invalid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= SETPOINT_RST;
      max_temp_r    <= MAX_TEMP_RST;
      deadband_r    <= DEADBAND_RST;
      large_error_r <= LARGE_ERROR_RST;
      rest_ticks_r  <= REST_TICKS_RST;
      open_pulse_r  <= OPEN_PULSE_RST;
      close_pulse_r <= CLOSE_PULSE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SETPOINT:    setpoint_r    <= cfg_wdata;
        REG_MAX_TEMP:    max_temp_r    <= cfg_wdata[MAXT_W-1:0];
        REG_DEADBAND:    deadband_r    <= cfg_wdata[BAND_W-1:0];
        REG_LARGE_ERROR: large_error_r <= cfg_wdata[BAND_W-1:0];
        REG_REST_TICKS:  rest_ticks_r  <= cfg_wdata[TICK_W-1:0];
        REG_OPEN_PULSE:  open_pulse_r  <= cfg_wdata[TICK_W-1:0];
        REG_CLOSE_PULSE: close_pulse_r <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_temp_r <= in_temp_out;
    end
  end

  // decision
  assign sp_x     = EXT_W'(setpoint_r);
  assign temp_x   = EXT_W'(s1_temp_r);
  assign maxt_x   = signed'({{(EXT_W-MAXT_W){1'b0}}, max_temp_r});
  assign db_x     = signed'({{(EXT_W-BAND_W){1'b0}}, deadband_r});
  assign big_x    = signed'({{(EXT_W-BAND_W){1'b0}}, large_error_r});
  assign cold_err = sp_x - temp_x;
  assign hot_err  = temp_x - sp_x;
  assign invalid  = (sp_x <= 0) || (sp_x > maxt_x) || (temp_x > maxt_x);

  always_comb begin
    wait_left_nxt = wait_left_r;
    pump_nxt      = pump_r;
    valve_nxt     = valve_r;
    eval_nxt      = 1'b0;
    if (wait_left_r != '0) begin
      wait_left_nxt = wait_left_r - 1'b1;
    end else begin
      eval_nxt      = 1'b1;
      wait_left_nxt = '0;
      if (invalid) begin
        pump_nxt  = 1'b0;
        valve_nxt = VALVE_CLOSE;
      end else begin
        pump_nxt = 1'b1;
        priority if (valve_r != VALVE_STOP) begin
          valve_nxt     = VALVE_STOP;
          wait_left_nxt = tick_wait(rest_ticks_r);
        end else if (cold_err >= db_x) begin
          valve_nxt = VALVE_OPEN;
          if (cold_err > big_x) wait_left_nxt = tick_wait(open_pulse_r);
        end else if (hot_err >= db_x) begin
          valve_nxt = VALVE_CLOSE;
          if (hot_err > big_x) wait_left_nxt = tick_wait(close_pulse_r);
        end else begin
          valve_nxt = VALVE_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_left_r <= '0;
      pump_r      <= 1'b0;
      valve_r     <= VALVE_STOP;
    end else if (s1_adv) begin
      wait_left_r <= wait_left_nxt;
      pump_r      <= pump_nxt;
      valve_r     <= valve_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pump_r  <= pump_nxt;
      out_valve_r <= valve_nxt;
      out_eval_r  <= eval_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pump_on   = out_pump_r;
  assign out_valve_cmd = out_valve_r;
  assign out_evaluated = out_eval_r;

endmodule
